// ===== rtl/lir_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
// No dependencies; imported by lir_ctrl, lir_lane and the top level.
package lir_pkg;

  localparam int NUM_CH           = 8;
  localparam int CNT_W            = 4;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF    = 24;
  localparam int MIN_STEP_SHIFT   = 6;
  localparam int CFG_IDX_W        = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_STEP_RATIO    = 2'd0;
  localparam cfg_idx_t REG_BYPASS        = 2'd1;
  localparam cfg_idx_t REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CNT_W-1:0] CH_COUNT_RESET = 4'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_PASS,
    S_RUN
  } state_t;

  typedef struct packed {
    logic capture;
    logic store_prev;
    logic issue;
    logic last;
    logic use_cur;
  } ctl_t;

endpackage

// ===== rtl/lir_lane.sv =====
// One channel of the interpolation datapath: difference, multiply by phase,
// register, then add back the previous sample. Depends on lir_pkg.
module lir_lane #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] prev_op,
  input  logic signed [SAMPLE_BITS-1:0] cur_op,
  input  logic        [FRAC_BITS-1:0]   frac,
  output logic signed [SAMPLE_BITS-1:0] sample
);
  import lir_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [SAMPLE_BITS:0]   sum;

  assign diff   = {cur_op[SAMPLE_BITS-1], cur_op} - {prev_op[SAMPLE_BITS-1], prev_op};
  assign frac_s = {1'b0, frac};
  assign prod   = diff * frac_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_q <= prod;
      prev_q <= prev_op;
    end
  end

  // floor of prod / 2^FRAC_BITS is the arithmetic shift
  assign sum    = {prev_q[SAMPLE_BITS-1], prev_q} + prod_q[FRAC_BITS+SAMPLE_BITS:FRAC_BITS];
  assign sample = sum[SAMPLE_BITS-1:0];

endmodule

// ===== rtl/lir_ctrl.sv =====
// Sequencer for the resampler: configuration registers, phase accumulator,
// priming flag and issue of one output frame per cycle while the output is not stalled. Depends on lir_pkg.
module lir_ctrl #(
  parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  lir_pkg::cfg_idx_t         cfg_index,
  input  logic [FRAC_BITS+2:0]      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      adv,
  output lir_pkg::ctl_t             ctl,
  output logic [FRAC_BITS-1:0]      frac,
  output logic [lir_pkg::CNT_W-1:0] nch
);
  import lir_pkg::*;

  localparam int SW = FRAC_BITS + 3;
  localparam int PW = FRAC_BITS + 4;
  localparam logic [SW-1:0] STEP_RESET = SW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] STEP_MIN   = SW'(1) << (FRAC_BITS - MIN_STEP_SHIFT);

  state_t            state;
  state_t            state_next;
  logic [SW-1:0]     step_ratio;
  logic              bypass;
  logic [CNT_W-1:0]  channel_count;
  logic [PW-1:0]     phase;
  logic              primed;

  logic [SW-1:0]     step_eff;
  logic [PW-1:0]     phase_sum;
  logic [PW-1:0]     phase_dec;
  logic [PW-1:0]     sum_dec;
  logic              run_ge;
  logic              sum_ge;

  assign step_eff  = (step_ratio < STEP_MIN) ? STEP_MIN : step_ratio;
  assign phase_sum = phase + {1'b0, step_eff};
  assign run_ge    = |phase[PW-1:FRAC_BITS];
  assign sum_ge    = |phase_sum[PW-1:FRAC_BITS];
  assign phase_dec = {phase[PW-1:FRAC_BITS] - 4'd1, phase[FRAC_BITS-1:0]};
  assign sum_dec   = {phase_sum[PW-1:FRAC_BITS] - 4'd1, phase_sum[FRAC_BITS-1:0]};

  always_comb begin
    if (channel_count == '0) begin
      nch = CNT_W'(1);
    end else if (channel_count > CNT_W'(NUM_CH)) begin
      nch = CNT_W'(NUM_CH);
    end else begin
      nch = channel_count;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (bypass) begin
            state_next = S_PASS;
          end else if (!primed) begin
            state_next = S_PRIME;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_PRIME: state_next = S_IDLE;
      S_PASS: begin
        if (adv) begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (run_ge || (adv && sum_ge)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    ctl            = '0;
    frac           = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      S_PRIME: ctl.store_prev = 1'b1;
      S_PASS: begin
        ctl.issue   = adv;
        ctl.last    = 1'b1;
        ctl.use_cur = 1'b1;
      end
      S_RUN: begin
        ctl.issue      = adv && !run_ge;
        ctl.last       = sum_ge;
        ctl.store_prev = run_ge || (adv && sum_ge);
        frac           = phase[FRAC_BITS-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step_ratio    <= STEP_RESET;
      bypass        <= 1'b1;
      channel_count <= CH_COUNT_RESET;
      phase         <= '0;
      primed        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == REG_STEP_RATIO) begin
        step_ratio <= cfg_wdata;
        phase      <= '0;
      end else if (state == S_RUN) begin
        if (run_ge) begin
          phase <= phase_dec;
        end else if (adv) begin
          phase <= sum_ge ? sum_dec : phase_sum;
        end
      end
      if (cfg_we && cfg_index == REG_BYPASS) begin
        bypass <= cfg_wdata[0];
      end
      if (cfg_we && cfg_index == REG_CHANNEL_COUNT) begin
        channel_count <= cfg_wdata[CNT_W-1:0];
      end
      if (state == S_PRIME) begin
        primed <= 1'b1;
      end
    end
  end

  a_issue_needs_adv: assert property (@(posedge clk) disable iff (rst)
    ctl.issue |-> adv)
    else $error("frame issued while output stage stalled");

  a_primed_holds: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped without reset");

  a_prime_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !bypass && !primed) |=> !ctl.issue && ctl.store_prev)
    else $error("priming frame did not store quietly");

endmodule

// ===== rtl/linear_interp_resampler.sv =====
// Linear interpolation resampler toward 48 kHz: up to eight channel lanes,
// sequencer and output register. Depends on lir_pkg, lir_ctrl and lir_lane.
//
// Channels: input frames on in_valid/in_ready, output frames on
// out_valid/out_ready, both taken when valid and ready are high together.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write them
// only while idle, which the block does not enforce; a write to step_ratio clears the phase.
// A frame is taken only when the sequencer is idle. An interpolating frame
// issues one output frame per cycle while the output is not stalled, one per phase
// position below one input frame (at most 64), and no new input is taken until it is done;
// priming and bypass frames pass through one state (S_PRIME or S_PASS) before idle.
// The first output frame passes the captured input, the lane product register and
// the output register: each lane registers its product and the add lands in the output register.
// Reset restores the register defaults (bypass on, two channels, unity
// step), clears the phase and the primed flag and empties the pipeline.
// When the receiver stalls, the output register and the lane stage hold and the
// sequencer issues no frame; no frame is lost or repeated.
module linear_interp_resampler #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  lir_pkg::cfg_idx_t             cfg_index,
  input  logic [FRAC_BITS+2:0]          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_1,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_2,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_3,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_4,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_5,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_6,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_7,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_0,
  output logic signed [SAMPLE_BITS-1:0] out_sample_1,
  output logic signed [SAMPLE_BITS-1:0] out_sample_2,
  output logic signed [SAMPLE_BITS-1:0] out_sample_3,
  output logic signed [SAMPLE_BITS-1:0] out_sample_4,
  output logic signed [SAMPLE_BITS-1:0] out_sample_5,
  output logic signed [SAMPLE_BITS-1:0] out_sample_6,
  output logic signed [SAMPLE_BITS-1:0] out_sample_7,
  output logic                          last_of_run
);
  import lir_pkg::*;

  logic signed [SAMPLE_BITS-1:0] in_frame  [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] cur       [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] prev      [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] lane_out  [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] out_frame [NUM_CH];

  ctl_t                 ctl;
  logic [FRAC_BITS-1:0] frac;
  logic [CNT_W-1:0]     nch;
  logic                 adv;
  logic                 s1_valid;
  logic                 s1_last;

  assign in_frame[0] = in_sample_0;
  assign in_frame[1] = in_sample_1;
  assign in_frame[2] = in_sample_2;
  assign in_frame[3] = in_sample_3;
  assign in_frame[4] = in_sample_4;
  assign in_frame[5] = in_sample_5;
  assign in_frame[6] = in_sample_6;
  assign in_frame[7] = in_sample_7;

  assign adv = !out_valid || out_ready;

  lir_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .adv       (adv),
    .ctl       (ctl),
    .frac      (frac),
    .nch       (nch)
  );

  for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (ctl.capture) begin
        cur[i] <= in_frame[i];
      end
      if (rst) begin
        prev[i] <= '0;
      end else if (ctl.store_prev) begin
        prev[i] <= cur[i];
      end
    end

    lir_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (adv),
      .prev_op (ctl.use_cur ? cur[i] : prev[i]),
      .cur_op  (cur[i]),
      .frac    (frac),
      .sample  (lane_out[i])
    );

    always_ff @(posedge clk) begin
      if (adv && s1_valid) begin
        out_frame[i] <= (CNT_W'(i) < nch) ? lane_out[i] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= ctl.issue;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= ctl.last;
      if (s1_valid) begin
        last_of_run <= s1_last;
      end
    end
  end

  assign out_sample_0 = out_frame[0];
  assign out_sample_1 = out_frame[1];
  assign out_sample_2 = out_frame[2];
  assign out_sample_3 = out_frame[3];
  assign out_sample_4 = out_frame[4];
  assign out_sample_5 = out_frame[5];
  assign out_sample_6 = out_frame[6];
  assign out_sample_7 = out_frame[7];

endmodule

// ===== tb/linear_interp_resampler_test.sv =====
// Self-checking testbench for linear_interp_resampler: a bursty frame driver,
// a stalling output monitor and an in-line linear interpolation predictor.
// Depends on lir_pkg and the linear_interp_resampler RTL.
module linear_interp_resampler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lir_pkg::*;

  typedef logic [NUM_CH-1:0][23:0] frame_t;

  typedef struct packed {
    frame_t smp;
    logic   last;
  } out_frame_t;

  localparam cfg_idx_t    REG_UNUSED  = 2'd3;
  localparam logic [23:0] SMP_MAX     = 24'h7FFFFF;
  localparam logic [23:0] SMP_MIN     = 24'h800000;
  localparam longint      PHASE_ONE   = 64'd1 << 24;
  localparam longint      STEP_FLOOR  = PHASE_ONE >> MIN_STEP_SHIFT;
  localparam int          MAX_RUN     = 64;
  localparam int          RAND_ITEMS  = 430;
  localparam int          SETTLE      = 16;
  localparam int          CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = REG_STEP_RATIO;
  logic [26:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  frame_t      in_bus = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  wire  [NUM_CH-1:0][23:0] out_bus;
  logic        last_of_run;

  // predictor state and register copies
  logic [26:0] step_cfg = 27'd16777216;
  logic        bypass_cfg = 1'b1;
  logic [3:0]  chan_cfg = CH_COUNT_RESET;
  frame_t      prev_frame = '0;
  longint      phase = 0;
  bit          primed = 1'b0;

  frame_t      frames_to_send[$];
  out_frame_t  out_expected[$];
  frame_t      held_frame = '0;

  int burst_left = 0;
  int gap_left = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  int pattern_left = 0;

  int frames_taken = 0;
  int results_checked = 0;
  int settings_used = 0;
  int mismatches = 0;
  int cycle_count = 0;

  int source_rates[10] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000,
                           88200, 96000, 192000};

  linear_interp_resampler u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_0  (in_bus[0]),
    .in_sample_1  (in_bus[1]),
    .in_sample_2  (in_bus[2]),
    .in_sample_3  (in_bus[3]),
    .in_sample_4  (in_bus[4]),
    .in_sample_5  (in_bus[5]),
    .in_sample_6  (in_bus[6]),
    .in_sample_7  (in_bus[7]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample_0 (out_bus[0]),
    .out_sample_1 (out_bus[1]),
    .out_sample_2 (out_bus[2]),
    .out_sample_3 (out_bus[3]),
    .out_sample_4 (out_bus[4]),
    .out_sample_5 (out_bus[5]),
    .out_sample_6 (out_bus[6]),
    .out_sample_7 (out_bus[7]),
    .last_of_run  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void add_frame(input frame_t f);
    frames_to_send.insert(frames_to_send.size(), f);
  endfunction

  function automatic void resample_frame(input frame_t cur);
    out_frame_t o;
    longint     stp;
    longint     p;
    longint     d;
    int         nch;
    int         n;
    nch = (chan_cfg == 0) ? 1 : ((chan_cfg > NUM_CH) ? NUM_CH : int'(chan_cfg));
    if (bypass_cfg) begin
      o = '0;
      for (int c = 0; c < nch; c++) o.smp[c] = cur[c];
      o.last = 1'b1;
      out_expected.insert(out_expected.size(), o);
      return;
    end
    if (!primed) begin
      prev_frame = cur;
      primed = 1'b1;
      return;
    end
    stp = step_cfg;
    if (stp < STEP_FLOOR) stp = STEP_FLOOR;
    n = 0;
    while (phase < PHASE_ONE && n < MAX_RUN) begin
      o = '0;
      for (int c = 0; c < nch; c++) begin
        p = longint'($signed(prev_frame[c]));
        d = longint'($signed(cur[c])) - p;
        o.smp[c] = 24'(p + ((d * phase) >>> 24));
      end
      phase += stp;
      n++;
      o.last = !(phase < PHASE_ONE && n < MAX_RUN);
      out_expected.insert(out_expected.size(), o);
    end
    if (phase >= PHASE_ONE) phase -= PHASE_ONE;
    prev_frame = cur;
  endfunction

  function automatic void check_result();
    out_frame_t want;
    bit         bad;
    results_checked++;
    if (out_expected.size() == 0) begin
      if (mismatches < 10)
        $display("output frame %0d not expected: %h last %b", results_checked, out_bus,
                 last_of_run);
      mismatches++;
      return;
    end
    want = out_expected.pop_front();
    bad = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (out_bus[c] !== want.smp[c]) begin
        if (mismatches < 10)
          $display("output frame %0d ch%0d: expected %0d, got %0d", results_checked, c,
                   $signed(want.smp[c]), $signed(out_bus[c]));
        bad = 1'b1;
      end
    end
    if (last_of_run !== want.last) begin
      if (mismatches < 10)
        $display("output frame %0d last_of_run: expected %b, got %b", results_checked,
                 want.last, last_of_run);
      bad = 1'b1;
    end
    if (bad) mismatches++;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int     style;
    style = $urandom_range(0, 9);
    for (int c = 0; c < NUM_CH; c++) begin
      if (style == 0) begin
        case ($urandom_range(0, 3))
          0: f[c] = SMP_MAX;
          1: f[c] = SMP_MIN;
          2: f[c] = '0;
          default: f[c] = '1;
        endcase
      end else if (style == 1) begin
        f[c] = 24'($urandom_range(0, 511)) - 24'd256;
      end else begin
        f[c] = 24'($urandom);
      end
    end
    return f;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [26:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STEP_RATIO: begin
        step_cfg = value;
        phase = 0;
      end
      REG_BYPASS: bypass_cfg = value[0];
      REG_CHANNEL_COUNT: chan_cfg = value[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_valid || out_expected.size() != 0);
    repeat (SETTLE) @(negedge clk);
    settings_used++;
  endtask

  // frame driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resample_frame(held_frame);
        frames_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (frames_to_send.size() > 0) begin
          held_frame = frames_to_send.pop_front();
          in_bus <= held_frame;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(12, 30);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: ready follows a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = 16'hFFFF;
          1: ready_pat = 16'($urandom) | 16'h0001;
          2: ready_pat = 16'h8000;
          default: ready_pat = 16'hF0F0;
        endcase
        pattern_left = $urandom_range(16, 300);
      end
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      pattern_left--;
      out_ready <= ready_pat[0];
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d output frames outstanding", cycle_count,
               out_expected.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int     sent;
    int     count;
    longint stp;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bypass out of reset, two channels
    add_frame({NUM_CH{SMP_MAX}});
    add_frame({NUM_CH{SMP_MIN}});
    add_frame(random_frame());
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, 27'd8);
    add_frame({4{24'h000000, 24'hFFFFFF}});
    wait_drained();
    // channel count zero and out of range
    write_reg(REG_CHANNEL_COUNT, {23'($urandom), 4'd0});
    add_frame(random_frame());
    wait_drained();
    write_reg(REG_CHANNEL_COUNT, {23'($urandom), 4'd15});
    add_frame(random_frame());
    wait_drained();

    // prime, then full-scale swings
    write_reg(REG_CHANNEL_COUNT, 27'd8);
    write_reg(REG_STEP_RATIO, 27'd12582912);
    write_reg(REG_BYPASS, {26'($urandom), 1'b0});
    add_frame({NUM_CH{SMP_MIN}});
    add_frame({NUM_CH{SMP_MAX}});
    add_frame({NUM_CH{SMP_MIN}});
    add_frame('0);
    add_frame('1);
    wait_drained();
    // large step: frames without output
    write_reg(REG_STEP_RATIO, 27'd67108864);
    repeat (5) add_frame(random_frame());
    wait_drained();
    // step below the floor, and the floor itself
    write_reg(REG_STEP_RATIO, 27'd0);
    repeat (2) add_frame(random_frame());
    wait_drained();
    write_reg(REG_STEP_RATIO, 27'(STEP_FLOOR));
    add_frame(random_frame());
    wait_drained();
    write_reg(REG_STEP_RATIO, 27'h7FFFFFF);
    repeat (3) add_frame(random_frame());
    wait_drained();
    // unknown register index: no effect
    write_reg(REG_UNUSED, 27'($urandom));
    repeat (2) add_frame(random_frame());
    wait_drained();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5:
            stp = (longint'(source_rates[$urandom_range(0, 9)]) << 24) / 48000;
          6, 7: stp = $urandom_range(262144, 67108864);
          8: stp = $urandom_range(0, 262143);
          default: stp = $urandom & 32'h07FFFFFF;
        endcase
        write_reg(REG_STEP_RATIO, 27'(stp));
      end
      write_reg(REG_BYPASS, {26'($urandom), 1'($urandom_range(0, 4) == 0)});
      if ($urandom_range(0, 4) == 0)
        write_reg(REG_CHANNEL_COUNT, {23'($urandom), 4'($urandom_range(0, 15))});
      else
        write_reg(REG_CHANNEL_COUNT, {23'($urandom), 4'($urandom_range(1, 8))});
      stp = (step_cfg < STEP_FLOOR) ? STEP_FLOOR : longint'(step_cfg);
      if (bypass_cfg || stp >= PHASE_ONE / 4) count = $urandom_range(15, 40);
      else if (stp >= PHASE_ONE / 16) count = $urandom_range(6, 15);
      else count = $urandom_range(2, 5);
      repeat (count) add_frame(random_frame());
      sent += count;
      wait_drained();
    end

    $display("%0d input frames over %0d register settings, %0d output frames checked",
             frames_taken, settings_used, results_checked);
    $display("%0d output frames mismatched", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
